// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk_i and masked during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define TCGP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcgp assertion failed");

// expression must never be true out of reset
`define TCGP_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("tcgp forbidden condition");

`endif

// ===== hdl/tcgp_pkg.sv =====
// ---------------------------------------------------------------------------
// tcgp_pkg
// Shared types, constants and font ROM of the glyph plotter.
// ---------------------------------------------------------------------------
package tcgp_pkg;

  localparam int unsigned DimW   = 11;
  localparam int unsigned PosW   = 10;
  localparam int unsigned MaskW  = 3;
  localparam int unsigned GlyphW = 15;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DimW-1:0] MaxDim     = 11'd1024;
  localparam logic [DimW-1:0] PosMax     = 11'd2047;
  localparam logic [DimW-1:0] WidthRst   = 11'd320;
  localparam logic [DimW-1:0] HeightRst  = 11'd240;
  localparam logic [7:0]      CodeFirst  = 8'h21;
  localparam logic [7:0]      CodeEnd    = 8'h7F;
  localparam logic [DimW:0]   LineStep   = 12'd6;
  localparam logic [DimW:0]   CharStep   = 12'd4;
  localparam logic [DimW:0]   GlyphWd    = 12'd3;
  localparam logic [DimW:0]   GlyphHt    = 12'd5;

  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;

  localparam logic KindRow    = 1'b0;
  localparam logic KindScroll = 1'b1;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [2:0] LastRow = 3'd4;

  typedef struct packed {
    logic              scroll;
    logic              draw;
    logic [PosW-1:0]   x;
    logic [PosW-1:0]   y;
    logic [GlyphW-1:0] glyph;
  } cmd_t;

  // one octal digit per row, top row first; 4 = left pixel
  localparam logic [GlyphW-1:0] FONT [94] = '{
    15'o22202, 15'o55000, 15'o07570, 15'o76737, 15'o51245, 15'o24653, 15'o22000,
    15'o12221, 15'o42224, 15'o52725, 15'o02720, 15'o00062, 15'o00700, 15'o00002,
    15'o11244, 15'o25552, 15'o62227, 15'o61247, 15'o61216, 15'o55711, 15'o74616,
    15'o24652, 15'o71111, 15'o25252, 15'o35311, 15'o02020, 15'o02062, 15'o12421,
    15'o07070, 15'o42124, 15'o61302, 15'o75547, 15'o25755, 15'o65656, 15'o34443,
    15'o65556, 15'o74647, 15'o74644, 15'o24553, 15'o55755, 15'o72227, 15'o11152,
    15'o55655, 15'o44447, 15'o77755, 15'o17774, 15'o25552, 15'o65644, 15'o25573,
    15'o65655, 15'o34216, 15'o72222, 15'o55557, 15'o55572, 15'o55777, 15'o55255,
    15'o55222, 15'o71247, 15'o32223, 15'o44211, 15'o62226, 15'o25000, 15'o00007,
    15'o42100, 15'o25755, 15'o65656, 15'o34443, 15'o65556, 15'o74647, 15'o74644,
    15'o24553, 15'o55755, 15'o72227, 15'o11152, 15'o55655, 15'o44447, 15'o77755,
    15'o17774, 15'o25552, 15'o65644, 15'o25573, 15'o65655, 15'o34216, 15'o72222,
    15'o55557, 15'o55572, 15'o55777, 15'o55255, 15'o55222, 15'o71247, 15'o12621,
    15'o22222, 15'o42324, 15'o02520
  };

endpackage

// ===== hdl/text_console_glyph_plotter_top.sv =====
// Path: each command is registered in the queue and then in the result sequencer.
// Output: a drawn glyph gives five row writes on the result port, a scroll one more;
//   the result sequencer sets this, a 2-entry queue lets input run ahead.
// Characters that draw nothing and do not scroll push no command and give no result.
// Reset: cursor at column 0, row 0, line start; width 320, height 240.
// ---------------------------------------------------------------------------
// text_console_glyph_plotter_top
// 3x5 font text console: characters in, scroll and glyph row writes out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_glyph_plotter_top import tcgp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_code_i,
  input  logic               end_of_line_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [PosW-1:0]    pixel_x_o,
  output logic [PosW-1:0]    pixel_y_o,
  output logic [MaskW-1:0]   row_mask_o,
  output logic               last_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  tcgp_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .char_code_i, .end_of_line_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  tcgp_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  tcgp_back u_back (
    .clk_i, .rst_ni,
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o, .out_ready_i, .kind_o, .pixel_x_o, .pixel_y_o, .row_mask_o, .last_o
  );

  `TCGP_ASSERT(a_scroll_zero, out_valid_o && kind_o |-> pixel_x_o == '0 && pixel_y_o == '0 && row_mask_o == '0)
  `TCGP_ASSERT(a_burst_cont, out_valid_o && out_ready_i && !last_o |=> out_valid_o && kind_o == KindRow)
  `TCGP_ASSERT(a_row_step, out_valid_o && out_ready_i && !last_o && kind_o == KindRow |=> pixel_y_o == $past(pixel_y_o) + 10'd1 && pixel_x_o == $past(pixel_x_o))

endmodule

// ===== hdl/tcgp_front.sv =====
// ---------------------------------------------------------------------------
// tcgp_front
// Takes characters, keeps the cursor and builds one command per character that scrolls or draws.
// ---------------------------------------------------------------------------
module tcgp_front import tcgp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_code_i,
  input  logic               end_of_line_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output cmd_t               push_cmd_o
);

  logic [DimW-1:0] width_q, height_q;
  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic            sol_q, sol_d;

  logic [DimW-1:0] w, h;
  logic [DimW-1:0] row1, col1;
  logic [DimW:0]   col_inc, row_inc;
  logic            scroll, draw, printable;
  logic [6:0]      font_idx;
  logic [7:0]      code_off;
  logic            accept;

  assign w = (width_q  > MaxDim) ? MaxDim : width_q;
  assign h = (height_q > MaxDim) ? MaxDim : height_q;

  always_comb begin
    scroll    = sol_q && (({1'b0, row_q} + LineStep) > {1'b0, h});
    row1      = row_q;
    if (scroll) begin
      row1 = (row_q >= LineStep[DimW-1:0]) ? row_q - LineStep[DimW-1:0] : '0;
    end
    col1      = sol_q ? '0 : col_q;
    printable = (char_code_i >= CodeFirst) && (char_code_i < CodeEnd);
    draw      = printable && (({1'b0, col1} + GlyphWd) <= {1'b0, w})
                && (({1'b0, row1} + GlyphHt) <= {1'b0, h});
    col_inc   = {1'b0, col1} + CharStep;
    row_inc   = {1'b0, row1} + LineStep;
    if (end_of_line_i) begin
      col_d = '0;
      row_d = row_inc[DimW] ? PosMax : row_inc[DimW-1:0];
      sol_d = 1'b1;
    end else begin
      col_d = col_inc[DimW] ? PosMax : col_inc[DimW-1:0];
      row_d = row1;
      sol_d = 1'b0;
    end
  end

  assign code_off = char_code_i - CodeFirst;
  assign font_idx = code_off[6:0];

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = in_valid_i && (scroll || draw);

  always_comb begin
    push_cmd_o.scroll = scroll;
    push_cmd_o.draw   = draw;
    push_cmd_o.x      = col1[PosW-1:0];
    push_cmd_o.y      = row1[PosW-1:0];
    push_cmd_o.glyph  = printable ? FONT[font_idx] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      col_q    <= '0;
      row_q    <= '0;
      sol_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegWidth:  width_q  <= cfg_data_i;
          RegHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        sol_q <= sol_d;
      end
    end
  end

endmodule

// ===== hdl/tcgp_queue.sv =====
// ---------------------------------------------------------------------------
// tcgp_queue
// Two-entry command FIFO between front and back.
// ---------------------------------------------------------------------------
module tcgp_queue import tcgp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/tcgp_back.sv =====
// ---------------------------------------------------------------------------
// tcgp_back
// Plays out one command: optional scroll, then five glyph row writes if it draws.
// ---------------------------------------------------------------------------
module tcgp_back import tcgp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  cmd_t             pop_cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [PosW-1:0]  pixel_x_o,
  output logic [PosW-1:0]  pixel_y_o,
  output logic [MaskW-1:0] row_mask_o,
  output logic             last_o
);

  logic        busy_q;
  logic        scr_q, scr_d;
  logic [2:0]  idx_q, idx_d;
  cmd_t        cur_q;
  logic        fire, done;

  assign out_valid_o = busy_q;
  assign fire        = busy_q && out_ready_i;
  assign last_o      = scr_q ? !cur_q.draw : (idx_q == LastRow);
  assign done        = fire && last_o;
  assign pop_ready_o = !busy_q || done;

  always_comb begin
    kind_o     = scr_q ? KindScroll : KindRow;
    pixel_x_o  = scr_q ? '0 : cur_q.x;
    pixel_y_o  = scr_q ? '0 : cur_q.y + PosW'(idx_q);
    row_mask_o = '0;
    if (!scr_q) begin
      case (idx_q)
        3'd0:    row_mask_o = cur_q.glyph[14:12];
        3'd1:    row_mask_o = cur_q.glyph[11:9];
        3'd2:    row_mask_o = cur_q.glyph[8:6];
        3'd3:    row_mask_o = cur_q.glyph[5:3];
        default: row_mask_o = cur_q.glyph[2:0];
      endcase
    end
  end

  always_comb begin
    scr_d = scr_q;
    idx_d = idx_q;
    if (fire) begin
      if (scr_q) scr_d = 1'b0;
      else       idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      cur_q <= pop_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      scr_q  <= 1'b0;
      idx_q  <= '0;
    end else if (pop_ready_o) begin
      busy_q <= pop_valid_i;
      scr_q  <= pop_cmd_i.scroll;
      idx_q  <= '0;
    end else begin
      scr_q <= scr_d;
      idx_q <= idx_d;
    end
  end

endmodule

// ===== dv/text_console_glyph_plotter_top_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_plotter_top_tb
// Self-checking bench for the 3x5 glyph plotter. A short table of directed
// characters runs first, then random lines under a sweep of screen sizes.
// Each accepted character goes through a local cursor and font model, and the
// scroll and row-write requests it should cause are queued and compared in
// order against the result port. Both handshakes idle at random but in phase 3.
// ----------------------------------------------------------------------------
module text_console_glyph_plotter_top_tb import tcgp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegFirstUnused = 2'd2;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned NumPhases = 9;

  // what one character turns into: an optional scroll, then an optional glyph
  typedef struct packed {
    bit            scroll;
    bit            draw;
    bit [PosW-1:0] x;
    bit [PosW-1:0] y;
    bit [14:0]     glyph;
  } glyph_job_t;

  typedef struct packed {
    logic             kind;
    logic [PosW-1:0]  x;
    logic [PosW-1:0]  y;
    logic [MaskW-1:0] mask;
    logic             last;
  } plot_res_t;

  typedef struct packed {
    bit [7:0]   code;
    bit         eol;
    bit         typed;
    glyph_job_t gold;
  } dir_row_t;

  // 3x5 font, codes 0x21..0x7E, one octal digit per row, top row first
  localparam bit [14:0] FontBits [94] = '{
    15'o22202, 15'o55000, 15'o07570, 15'o76737, 15'o51245, 15'o24653, 15'o22000,
    15'o12221, 15'o42224, 15'o52725, 15'o02720, 15'o00062, 15'o00700, 15'o00002,
    15'o11244, 15'o25552, 15'o62227, 15'o61247, 15'o61216, 15'o55711, 15'o74616,
    15'o24652, 15'o71111, 15'o25252, 15'o35311, 15'o02020, 15'o02062, 15'o12421,
    15'o07070, 15'o42124, 15'o61302, 15'o75547, 15'o25755, 15'o65656, 15'o34443,
    15'o65556, 15'o74647, 15'o74644, 15'o24553, 15'o55755, 15'o72227, 15'o11152,
    15'o55655, 15'o44447, 15'o77755, 15'o17774, 15'o25552, 15'o65644, 15'o25573,
    15'o65655, 15'o34216, 15'o72222, 15'o55557, 15'o55572, 15'o55777, 15'o55255,
    15'o55222, 15'o71247, 15'o32223, 15'o44211, 15'o62226, 15'o25000, 15'o00007,
    15'o42100, 15'o25755, 15'o65656, 15'o34443, 15'o65556, 15'o74647, 15'o74644,
    15'o24553, 15'o55755, 15'o72227, 15'o11152, 15'o55655, 15'o44447, 15'o77755,
    15'o17774, 15'o25552, 15'o65644, 15'o25573, 15'o65655, 15'o34216, 15'o72222,
    15'o55557, 15'o55572, 15'o55777, 15'o55255, 15'o55222, 15'o71247, 15'o12621,
    15'o22222, 15'o42324, 15'o02520
  };

  // screen sizes swept by the random part; phase 3 runs without idling,
  // phase 5 holds the sender once until all results are back
  int unsigned phase_w [NumPhases] = '{2047, 3, 0, 1024, 2, 16, 1025, 8, 320};
  int unsigned phase_h [NumPhases] = '{2047, 6, 0, 1024, 4, 30, 5, 12, 240};
  int unsigned phase_n [NumPhases] = '{25, 25, 20, 25, 15, 30, 25, 20, 25};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DimW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         char_code_i;
  logic               end_of_line_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               kind_o;
  logic [PosW-1:0]    pixel_x_o;
  logic [PosW-1:0]    pixel_y_o;
  logic [MaskW-1:0]   row_mask_o;
  logic               last_o;

  // side info travelling with the request on the input channel
  bit         gold_typed;
  glyph_job_t gold_job;

  bit          no_idle = 1'b0;
  int unsigned mismatches = 0;
  plot_res_t   expected_plots [$];
  dir_row_t    dir_rows [$];

  // console model state
  bit [DimW-1:0] scr_w = WidthRst;
  bit [DimW-1:0] scr_h = HeightRst;
  int unsigned   pen_col = 0;
  int unsigned   pen_row = 0;
  bit            pen_line_start = 1'b1;

  text_console_glyph_plotter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .row_mask_o    (row_mask_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic glyph_job_t plot_step(bit [7:0] code, bit eol);
    glyph_job_t  job;
    int unsigned w;
    int unsigned h;
    job = '0;
    w = (scr_w > MaxDim) ? MaxDim : scr_w;
    h = (scr_h > MaxDim) ? MaxDim : scr_h;
    if (pen_line_start) begin
      if (pen_row + 6 > h) begin
        job.scroll = 1'b1;
        pen_row = (pen_row >= 6) ? pen_row - 6 : 0;
      end
      pen_col = 0;
      pen_line_start = 1'b0;
    end
    // whole glyph or nothing
    if (code >= CodeFirst && code < CodeEnd && pen_col + 3 <= w && pen_row + 5 <= h) begin
      job.draw = 1'b1;
      job.x = pen_col[PosW-1:0];
      job.y = pen_row[PosW-1:0];
      job.glyph = FontBits[code - CodeFirst];
    end
    pen_col = (pen_col + 4 > PosMax) ? PosMax : pen_col + 4;
    if (eol) begin
      pen_row = (pen_row + 6 > PosMax) ? PosMax : pen_row + 6;
      pen_col = 0;
      pen_line_start = 1'b1;
    end
    return job;
  endfunction

  function automatic void queue_plots(glyph_job_t job);
    plot_res_t r;
    if (job.scroll) begin
      r = '0;
      r.kind = KindScroll;
      r.last = !job.draw;
      expected_plots.push_back(r);
    end
    if (job.draw) begin
      for (int i = 0; i < 5; i++) begin
        r = '0;
        r.kind = KindRow;
        r.x = job.x;
        r.y = job.y + PosW'(i);
        r.mask = MaskW'(job.glyph >> (3 * (4 - i)));
        r.last = (i == 4);
        expected_plots.push_back(r);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void add_row(bit [7:0] code, bit eol, bit typed, bit scroll, bit draw,
                                  int unsigned x, int unsigned y, bit [14:0] glyph);
    dir_row_t row;
    row.code = code;
    row.eol = eol;
    row.typed = typed;
    row.gold.scroll = scroll;
    row.gold.draw = draw;
    row.gold.x = x[PosW-1:0];
    row.gold.y = y[PosW-1:0];
    row.gold.glyph = glyph;
    dir_rows.push_back(row);
  endfunction

  function automatic bit [7:0] rand_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 90) return 8'h20;
    return 8'($urandom_range(255));
  endfunction

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin : monitor
    plot_res_t  want;
    glyph_job_t job;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        job = plot_step(char_code_i, end_of_line_i);
        queue_plots(gold_typed ? gold_job : job);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_plots.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %0d %0d %0d %0d %0d",
                   $time, kind_o, pixel_x_o, pixel_y_o, row_mask_o, last_o);
          mismatches++;
        end else begin
          want = expected_plots.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_o));
          check_field("pixel_x", 32'(want.x), 32'(pixel_x_o));
          check_field("pixel_y", 32'(want.y), 32'(pixel_y_o));
          check_field("row_mask", 32'(want.mask), 32'(row_mask_o));
          check_field("last", 32'(want.last), 32'(last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_char(bit [7:0] code, bit eol, bit typed, glyph_job_t gold);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= code;
    end_of_line_i <= eol;
    gold_typed    <= typed;
    gold_job      <= gold;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the sender until every request has been answered, then let the
  // silent characters still in flight settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_plots.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(bit [DimW-1:0] w, bit [DimW-1:0] h);
    logic [CfgIdxW-1:0] junk_idx;
    logic [DimW-1:0]    junk_data;
    junk_idx = RegFirstUnused + CfgIdxW'($urandom_range(1));
    junk_data = DimW'($urandom_range(2047));
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegWidth;
    cfg_data_i <= w;
    scr_w = w;
    @(posedge clk_i);
    cfg_index_i <= RegHeight;
    cfg_data_i <= h;
    scr_h = h;
    @(posedge clk_i);
    // unused index, must change nothing
    cfg_index_i <= junk_idx;
    cfg_data_i <= junk_data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned len;
    bit          broken;
    bit          eol;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= RegWidth;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    char_code_i   <= '0;
    end_of_line_i <= 1'b0;
    gold_typed    <= 1'b0;
    gold_job      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, default 320x240 screen
    add_row(8'h21, 1'b0, 1'b1, 1'b0, 1'b1, 0, 0, 15'o22202);
    add_row(8'h7E, 1'b0, 1'b1, 1'b0, 1'b1, 4, 0, 15'o02520);
    add_row(8'h20, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h7F, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h41, 1'b1, 1'b1, 1'b0, 1'b1, 0, 6, 15'o25755);
    add_row(8'h30, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h39, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h61, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h7A, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h40, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h5F, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h7C, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h55, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h20, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h4D, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    add_row(8'h22, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0, 15'o0);
    foreach (dir_rows[i]) send_char(dir_rows[i].code, dir_rows[i].eol, dir_rows[i].typed,
                                    dir_rows[i].gold);

    // random lines under each screen size
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      write_regs(DimW'(phase_w[p]), DimW'(phase_h[p]));
      no_idle = (p == 3);
      sent = 0;
      while (sent < phase_n[p]) begin
        len = $urandom_range(1, 10);
        broken = ($urandom_range(99) < 15);
        for (int k = 0; k < len; k++) begin
          eol = broken ? 1'($urandom_range(1)) : (k == len - 1);
          send_char(rand_code(), eol, 1'b0, '0);
          sent++;
          if (p == 5 && sent == 20) drain_results();
        end
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tcgp_pkg.sv
hdl/tcgp_front.sv
hdl/tcgp_queue.sv
hdl/tcgp_back.sv
hdl/text_console_glyph_plotter_top.sv
dv/text_console_glyph_plotter_top_tb.sv
